### src/kpinact_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpinact_pkg;

  // configuration register map
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_ACTIVE_TO_WANDER = 2'd0;
  localparam logic [1:0] REG_WANDER_TO_SLEEP  = 2'd1;
  localparam logic [1:0] REG_SLEEP_TO_WANDER  = 2'd2;

  localparam logic [31:0] ACTIVE_TO_WANDER_RST = 32'd5000;
  localparam logic [31:0] WANDER_TO_SLEEP_RST  = 32'd180000;
  localparam logic [31:0] SLEEP_TO_WANDER_RST  = 32'd60000;

  // key bit positions after inversion
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned PAD_A      = 0;
  localparam int unsigned PAD_B      = 1;
  localparam int unsigned PAD_SELECT = 2;
  localparam int unsigned PAD_START  = 3;
  localparam int unsigned PAD_RIGHT  = 4;
  localparam int unsigned PAD_LEFT   = 5;
  localparam int unsigned PAD_UP     = 6;
  localparam int unsigned PAD_DOWN   = 7;
  localparam int unsigned PAD_R      = 8;
  localparam int unsigned PAD_L      = 9;

  localparam logic [1:0] GAZE_CENTRE = 2'd0;
  localparam logic [1:0] GAZE_LEFT   = 2'd1;
  localparam logic [1:0] GAZE_RIGHT  = 2'd2;
  localparam logic [1:0] GAZE_UP     = 2'd1;
  localparam logic [1:0] GAZE_DOWN   = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_TIMEOUT   = 2'd1,
    ACT_SET_SLEEP = 2'd2,
    ACT_SET_IDLE  = 2'd3
  } action_e;

  typedef struct packed {
    logic [31:0] active_to_wander_ms;
    logic [31:0] wander_dwell_ms;
    logic [31:0] sleep_to_wander_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase_now;
    logic [1:0] phase_action;
    logic       doze_request;
    logic       happy_request;
    logic       wink_request;
    logic       press_event;
    logic       lid_right_closed;
    logic       lid_left_closed;
    logic [1:0] gaze_y;
    logic [1:0] gaze_x;
    logic       gaze_changed;
  } res_t;

endpackage

`default_nettype wire

### src/kpinact_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module kpinact_cfg import kpinact_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_to_wander_ms <= ACTIVE_TO_WANDER_RST;
      cfg_q.wander_dwell_ms     <= WANDER_TO_SLEEP_RST;
      cfg_q.sleep_to_wander_ms  <= SLEEP_TO_WANDER_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ACTIVE_TO_WANDER: cfg_q.active_to_wander_ms <= pwdata;
        REG_WANDER_TO_SLEEP:  cfg_q.wander_dwell_ms     <= pwdata;
        REG_SLEEP_TO_WANDER:  cfg_q.sleep_to_wander_ms  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACTIVE_TO_WANDER: prdata = cfg_q.active_to_wander_ms;
      REG_WANDER_TO_SLEEP:  prdata = cfg_q.wander_dwell_ms;
      REG_SLEEP_TO_WANDER:  prdata = cfg_q.sleep_to_wander_ms;
      default:              prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### src/kpinact_core.sv
`timescale 1ns / 1ps
`default_nettype none

module kpinact_core import kpinact_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [KEY_W-1:0] in_keys_n_i,
  input  wire logic [31:0]      in_now_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output res_t                  out_res_o
);

  typedef enum logic [1:0] {
    PH_ACTIVE = 2'd0,
    PH_WANDER = 2'd1,
    PH_SLEEP  = 2'd2
  } phase_e;

  // input register
  logic             s1_valid_q;
  logic [KEY_W-1:0] s1_keys_n_q;
  logic [31:0]      s1_now_q;

  // history and phase machine
  logic [KEY_W-1:0] prior_keys_q;
  logic [3:0]       prior_dir_q;
  logic [31:0]      last_act_q, last_act_d;
  logic [31:0]      phase_start_q, phase_start_d;
  phase_e           phase_q, phase_d;
  action_e          action_d;

  logic             out_valid_q;
  res_t             res_q, res_d;

  logic             adv, load, take;
  logic [KEY_W-1:0] keys, edges;
  logic [3:0]       dir;
  logic [31:0]      quiet, phase_age;

  assign adv        = !out_valid_q || out_ready_i;
  assign load       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;
  assign take       = in_valid_i && in_ready_o;

  assign keys      = ~s1_keys_n_q;
  assign dir       = keys[PAD_DOWN:PAD_RIGHT];
  assign edges     = keys & ~prior_keys_q;
  assign quiet     = s1_now_q - last_act_q;
  assign phase_age = s1_now_q - phase_start_q;

  always_comb begin
    last_act_d    = last_act_q;
    phase_start_d = phase_start_q;
    phase_d       = phase_q;
    action_d      = ACT_NONE;
    if (keys != '0) begin
      last_act_d = s1_now_q;
      if (phase_q != PH_ACTIVE) begin
        phase_d       = PH_ACTIVE;
        phase_start_d = s1_now_q;
      end
    end else begin
      case (phase_q)
        PH_ACTIVE: begin
          if (quiet > cfg_i.active_to_wander_ms) begin
            action_d      = ACT_TIMEOUT;
            phase_d       = PH_WANDER;
            phase_start_d = s1_now_q;
          end
        end
        PH_WANDER: begin
          if (phase_age > cfg_i.wander_dwell_ms) begin
            action_d      = ACT_SET_SLEEP;
            phase_d       = PH_SLEEP;
            phase_start_d = s1_now_q;
          end
        end
        PH_SLEEP: begin
          if (phase_age > cfg_i.sleep_to_wander_ms) begin
            action_d      = ACT_SET_IDLE;
            phase_d       = PH_WANDER;
            phase_start_d = s1_now_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d.gaze_changed     = (dir != prior_dir_q);
    res_d.gaze_x           = keys[PAD_RIGHT] ? GAZE_RIGHT :
                             keys[PAD_LEFT]  ? GAZE_LEFT  : GAZE_CENTRE;
    res_d.gaze_y           = keys[PAD_DOWN]  ? GAZE_DOWN  :
                             keys[PAD_UP]    ? GAZE_UP    : GAZE_CENTRE;
    res_d.lid_left_closed  = keys[PAD_L];
    res_d.lid_right_closed = keys[PAD_R];
    res_d.press_event      = edges[PAD_A];
    res_d.wink_request     = edges[PAD_B];
    res_d.happy_request    = edges[PAD_START];
    res_d.doze_request     = edges[PAD_SELECT];
    res_d.phase_action     = action_d;
    res_d.phase_now        = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      prior_keys_q  <= '0;
      prior_dir_q   <= '0;
      last_act_q    <= '0;
      phase_start_q <= '0;
      phase_q       <= PH_ACTIVE;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (load) begin
        prior_keys_q  <= keys;
        prior_dir_q   <= dir;
        last_act_q    <= last_act_d;
        phase_start_q <= phase_start_d;
        phase_q       <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_keys_n_q <= in_keys_n_i;
      s1_now_q    <= in_now_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // a held key always forces the active phase with no command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && keys != '0) |=> (res_q.phase_action == ACT_NONE && phase_q == PH_ACTIVE))
    else $error("key held but phase not active");

  // any timed transition restarts the phase clock at the item time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && action_d != ACT_NONE) |=> (phase_start_q == $past(s1_now_q)))
    else $error("phase start not updated on transition");

  // set-sleep command lands in sleep, others never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ((res_q.phase_action == ACT_SET_SLEEP) == (phase_q == PH_SLEEP &&
              $past(phase_q) == PH_WANDER)))
    else $error("sleep entry and command disagree");

  // result word reflects the phase it left behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (res_q.phase_now == phase_q))
    else $error("reported phase differs from state");

endmodule

`default_nettype wire

### src/keypad_inactivity_phase_fsm.sv
// keypad inactivity phase machine
// s_axis carries one word per frame: a sample of the active-low 10-key pad and
// the current millisecond time. m_axis returns one result word per input word,
// in order: gaze change and coded gaze position, lid flags from the shoulder
// keys, rising-edge requests for A, B, START and SELECT, and the phase command
// and phase (active, wander, sleep) after the word.
// the APB port holds three 32-bit thresholds at 0x0, 0x4 and 0x8; compares are
// strict greater-than on wrapping time differences. write them only when idle.
// a word accepted on s_axis is held in the input register, and its result is
// loaded into the output register once that register is free.
// throughput is one word per cycle unless m_axis stalls, set by the single
// compute stage between input and output registers, which updates key history.
// when m_axis stalls, the result and input registers hold and s_axis_tready
// drops only once both are full.
// reset clears both stages and the history, returns the phase to active and
// reloads the thresholds with 5000, 180000 and 60000 ms.
`timescale 1ns / 1ps
`default_nettype none

module keypad_inactivity_phase_fsm import kpinact_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [9:0] key_levels_n, [41:10] now_ms, [47:42] zero
  input  wire logic [47:0]       s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] gaze_changed, [2:1] gaze_x, [4:3] gaze_y, [5] lid_left_closed,
  // [6] lid_right_closed, [7] press_event, [8] wink_request, [9] happy_request,
  // [10] doze_request, [12:11] phase_action, [14:13] phase_now, [15] zero
  output logic      [15:0]       m_axis_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;
  res_t res;

  kpinact_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kpinact_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_keys_n_i (s_axis_tdata[9:0]),
    .in_now_i    (s_axis_tdata[41:10]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // res_t is declared lowest field last, so it packs straight into the word
  assign m_axis_tdata = {1'b0, res};

endmodule

`default_nettype wire
